// ===== hdl/vmt_pkg.sv =====
package vmt_pkg;

    // sizes fixed by the field formats
    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = 12;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHIFT_W    = SUM_W - FRAC_BITS;

    // defaults for top level parameters
    localparam int MAX_VERTICES_DEF = 65536;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // register stages in the back end, output register included
    localparam int BACK_STAGES = 3;

    // reset values of the window registers
    localparam logic [CFG_W-1:0] WINDOW_START_RST = CFG_W'(0);
    localparam logic [CFG_W-1:0] WINDOW_COUNT_RST = CFG_W'(1);
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START = 3'd0,
        REG_WINDOW_COUNT = 3'd1,
        REG_MATRIX_ROW0  = 3'd2,
        REG_MATRIX_ROW1  = 3'd3,
        REG_MATRIX_ROW2  = 3'd4,
        REG_MATRIX_ROW3  = 3'd5
    } cfg_reg_t;

    // matrix[r][j] is row r, column j
    typedef logic [3:0][COEF_W-1:0] mat_row_t;
    typedef mat_row_t [3:0] matrix_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
        logic signed [COORD_W-1:0] in_w;
        logic                      last_vertex;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic signed [COORD_W-1:0] out_w;
        logic                      out_last;
    } out_beat_t;

    // classified vertex handed from front to back
    typedef struct packed {
        in_beat_t beat;
        logic     sel;
    } work_t;

    // identity matrix after reset
    function automatic matrix_t identity_matrix();
        matrix_t m;
        m = '0;
        for (int r = 0; r < 4; r++) begin
            m[r][r] = COEF_ONE;
        end
        return m;
    endfunction

endpackage

// ===== hdl/vmt_front.sv =====
module vmt_front #(
    parameter int MAX_VERTICES = vmt_pkg::MAX_VERTICES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  vmt_pkg::in_beat_t                s_beat,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vmt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_full,
    output logic                             q_push,
    output vmt_pkg::work_t                   q_item,
    output vmt_pkg::matrix_t                 matrix
);
    import vmt_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

    logic [CFG_W-1:0] window_start_reg, window_start_next;
    logic [CFG_W-1:0] window_count_reg, window_count_next;
    matrix_t          matrix_reg, matrix_next;
    logic [IDX_W-1:0] vertex_index_reg, vertex_index_next;

    logic             at_limit;
    logic             in_window;
    logic [CMP_W-1:0] idx_ext, first_ext, cnt_ext, offset;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    assign matrix    = matrix_reg;

    // register writes, unknown indexes dropped
    always_comb begin
        window_start_next = window_start_reg;
        window_count_next = window_count_reg;
        matrix_next       = matrix_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WINDOW_START: window_start_next = cfg_data[CFG_W-1:0];
                REG_WINDOW_COUNT: window_count_next = cfg_data[CFG_W-1:0];
                REG_MATRIX_ROW0:  matrix_next[0] = cfg_data;
                REG_MATRIX_ROW1:  matrix_next[1] = cfg_data;
                REG_MATRIX_ROW2:  matrix_next[2] = cfg_data;
                REG_MATRIX_ROW3:  matrix_next[3] = cfg_data;
                default: ;
            endcase
        end
    end

    // window test against the running index
    always_comb begin
        idx_ext   = CMP_W'(vertex_index_reg);
        first_ext = CMP_W'(window_start_reg) - CMP_W'(1);
        cnt_ext   = (window_count_reg == '0) ? CMP_W'(1) : CMP_W'(window_count_reg);
        offset    = idx_ext - first_ext;
        at_limit  = (vertex_index_reg == IDX_W'(MAX_VERTICES));
        in_window = !at_limit && (idx_ext >= first_ext) && (offset < cnt_ext);
        q_item.beat = s_beat;
        q_item.sel  = (window_start_reg == '0) || in_window;
    end

    // index restarts after the last vertex and stops at the limit
    always_comb begin
        vertex_index_next = vertex_index_reg;
        if (q_push) begin
            if (s_beat.last_vertex) begin
                vertex_index_next = '0;
            end else if (!at_limit) begin
                vertex_index_next = vertex_index_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_start_reg <= WINDOW_START_RST;
            window_count_reg <= WINDOW_COUNT_RST;
            matrix_reg       <= identity_matrix();
            vertex_index_reg <= '0;
        end else begin
            window_start_reg <= window_start_next;
            window_count_reg <= window_count_next;
            matrix_reg       <= matrix_next;
            vertex_index_reg <= vertex_index_next;
        end
    end

endmodule

// ===== hdl/vmt_queue.sv =====
module vmt_queue #(
    parameter int DEPTH = vmt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vmt_pkg::work_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output vmt_pkg::work_t pop_item
);
    import vmt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/vmt_back.sv =====
module vmt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  vmt_pkg::matrix_t   matrix,
    input  logic               q_valid,
    input  vmt_pkg::work_t     q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output vmt_pkg::out_beat_t m_beat
);
    import vmt_pkg::*;

    // stage 1: products
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [4][4];
    logic signed [PROD_W-1:0] s1_prod_next [4][4];
    in_beat_t                 s1_beat_reg;
    logic                     s1_sel_reg;

    // stage 2: row sums
    logic                     s2_valid_reg;
    logic signed [SUM_W-1:0]  s2_sum_reg [4];
    logic signed [SUM_W-1:0]  s2_sum_next [4];
    in_beat_t                 s2_beat_reg;
    logic                     s2_sel_reg;

    // stage 3: output register
    logic                     out_valid_reg;
    out_beat_t                out_beat_reg, out_beat_next;

    logic                     s1_ready, s2_ready, s3_ready;
    logic signed [COORD_W-1:0] vin [4];
    logic signed [COORD_W-1:0] vpass [4];
    logic signed [COORD_W-1:0] res [4];
    logic signed [COEF_W-1:0]  coef;
    logic signed [SHIFT_W-1:0] shifted;

    // per stage ready, bubbles collapse
    assign s3_ready = !out_valid_reg || m_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_pop    = q_valid && s1_ready;
    assign m_valid  = out_valid_reg;
    assign m_beat   = out_beat_reg;

    // one 16x32 multiply per coefficient
    always_comb begin
        vin[0] = q_item.beat.in_x;
        vin[1] = q_item.beat.in_y;
        vin[2] = q_item.beat.in_z;
        vin[3] = q_item.beat.in_w;
        coef   = '0;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                coef = matrix[r][j];
                s1_prod_next[r][j] = coef * vin[j];
            end
        end
    end

    // four-term row sums
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            s2_sum_next[r] = SUM_W'(s1_prod_reg[r][0]) + SUM_W'(s1_prod_reg[r][1])
                           + SUM_W'(s1_prod_reg[r][2]) + SUM_W'(s1_prod_reg[r][3]);
        end
    end

    // floor shift, saturate, or pass the vertex through
    always_comb begin
        vpass[0] = s2_beat_reg.in_x;
        vpass[1] = s2_beat_reg.in_y;
        vpass[2] = s2_beat_reg.in_z;
        vpass[3] = s2_beat_reg.in_w;
        shifted  = '0;
        for (int r = 0; r < 4; r++) begin
            shifted = s2_sum_reg[r][SUM_W-1:FRAC_BITS];
            if (!s2_sel_reg) begin
                res[r] = vpass[r];
            end else if (shifted[SHIFT_W-1:COORD_W-1] == '0
                         || shifted[SHIFT_W-1:COORD_W-1] == '1) begin
                res[r] = shifted[COORD_W-1:0];
            end else if (shifted[SHIFT_W-1]) begin
                res[r] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                res[r] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
        out_beat_next.out_x    = res[0];
        out_beat_next.out_y    = res[1];
        out_beat_next.out_z    = res[2];
        out_beat_next.out_w    = res[3];
        out_beat_next.out_last = s2_beat_reg.last_vertex;
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_prod_reg <= s1_prod_next;
            s1_beat_reg <= q_item.beat;
            s1_sel_reg  <= q_item.sel;
        end
        if (s1_valid_reg && s2_ready) begin
            s2_sum_reg  <= s2_sum_next;
            s2_beat_reg <= s1_beat_reg;
            s2_sel_reg  <= s1_sel_reg;
        end
        if (s2_valid_reg && s3_ready) begin
            out_beat_reg <= out_beat_next;
        end
    end

endmodule

// ===== hdl/vertex_matrix_transform_unit.sv =====
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+------------------------------
// s_        | in        | s_valid / s_ready   | s_beat: vertex and last flag
// m_        | out       | m_valid / m_ready   | m_beat: result and last flag
// cfg_      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one beat per cycle while m_ready stays high; a taken input beat reaches m_ through
// the queue write, multiply stage, sum stage and output register, in that order
// synchronous active low reset clears the vertex index, queue and stage valids,
// and sets the window to all vertices and the matrix to identity
// s_ready drops only when the front queue is full; each back stage moves
// whenever the stage after it is empty or moving, so m_ready stalls back up
// through the back end into the queue
module vertex_matrix_transform_unit #(
    parameter int MAX_VERTICES = vmt_pkg::MAX_VERTICES_DEF,
    parameter int QUEUE_DEPTH  = vmt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  vmt_pkg::in_beat_t                s_beat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output vmt_pkg::out_beat_t               m_beat,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vmt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vmt_pkg::*;

    logic    q_full, q_push, q_pop, q_not_empty;
    work_t   q_in_item, q_out_item;
    matrix_t matrix;

    // classify and count vertices
    vmt_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item),
        .matrix    (matrix)
    );

    // decoupling queue
    vmt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_out_item)
    );

    // multiply, sum, saturate
    vmt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .matrix  (matrix),
        .q_valid (q_not_empty),
        .q_item  (q_out_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

endmodule

// ===== hdl/vmt_checker.sv =====
module vmt_checker #(
    parameter int QUEUE_DEPTH = vmt_pkg::QUEUE_DEPTH_DEF,
    parameter int CAPACITY    = vmt_pkg::QUEUE_DEPTH_DEF + vmt_pkg::BACK_STAGES
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input vmt_pkg::out_beat_t m_beat
);
    import vmt_pkg::*;

    localparam int OUT_W = $clog2(CAPACITY + 2);

    logic [OUT_W-1:0] outstanding_reg, outstanding_next;
    logic             s_take, m_take;

    assign s_take = s_valid && s_ready;
    assign m_take = m_valid && m_ready;

    // beats taken in but not yet delivered
    always_comb begin
        outstanding_next = outstanding_reg;
        if (s_take && !m_take) begin
            outstanding_next = outstanding_reg + OUT_W'(1);
        end else if (m_take && !s_take) begin
            outstanding_next = outstanding_reg - OUT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("result beat changed while stalled");

    // never more in flight than queue plus stages
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding_reg <= OUT_W'(CAPACITY))
        else $error("more beats in flight than the block can hold");

    // no result without a matching input
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != '0)
        else $error("result beat with no input beat outstanding");

    // queue has room whenever fewer beats than its depth are in flight
    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding_reg < OUT_W'(QUEUE_DEPTH) |-> s_ready)
        else $error("input stalled although queue has room");

endmodule

bind vertex_matrix_transform_unit vmt_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CAPACITY    (QUEUE_DEPTH + vmt_pkg::BACK_STAGES)
) u_vmt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_beat  (m_beat)
);
